FILE: rtl/cap_pkg.sv
`default_nettype none
package cap_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;

	localparam int FOLD_W = 3;
	localparam logic [FOLD_W-1:0] FOLD_RESET = 3'd2;

	localparam int CORDIC_STEPS = 23;
	localparam int XW = 62;
	localparam int ZW = 27;
	localparam int NORM_TOP = 57;
	localparam int NORM_STAGES = 6;
	localparam int ANG_W = 25;

	localparam logic signed [ZW-1:0] Q16_90 = ZW'(5898240);
	localparam logic signed [ZW-1:0] Q16_180 = ZW'(11796480);
	localparam logic signed [ZW-1:0] Q16_360 = ZW'(23592960);

	localparam int K_W = 38;
	localparam int K_SPLIT = 19;
	localparam logic [K_W-1:0] RAD2DEG_Q32 = 38'd246083499208;
	localparam logic [K_SPLIT-1:0] K_HI = RAD2DEG_Q32[K_W-1:K_SPLIT];
	localparam logic [K_SPLIT-1:0] K_LO = RAD2DEG_Q32[K_SPLIT-1:0];
	localparam int ROUND_BIT = 31;
	localparam int OUT_SHIFT = 32;

	typedef struct packed {
		logic amp_zero;
		logic pu_zero;
	} cap_flags_t;

	function automatic int max_int(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic signed [ZW-1:0] atan_deg(input int step);
		logic signed [ZW-1:0] v;
		case (step)
			0: v = ZW'(2949120);
			1: v = ZW'(1740967);
			2: v = ZW'(919879);
			3: v = ZW'(466945);
			4: v = ZW'(234379);
			5: v = ZW'(117304);
			6: v = ZW'(58666);
			7: v = ZW'(29335);
			8: v = ZW'(14668);
			9: v = ZW'(7334);
			10: v = ZW'(3667);
			11: v = ZW'(1833);
			12: v = ZW'(917);
			13: v = ZW'(458);
			14: v = ZW'(229);
			15: v = ZW'(115);
			16: v = ZW'(57);
			17: v = ZW'(29);
			18: v = ZW'(14);
			19: v = ZW'(7);
			20: v = ZW'(4);
			21: v = ZW'(2);
			22: v = ZW'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/cap_if.sv
`default_nettype none
interface cap_in_if #(
	parameter int DATA_WIDTH = 32
);
	logic valid;
	logic ready;
	logic signed [DATA_WIDTH-1:0] cos_coeff;
	logic signed [DATA_WIDTH-1:0] sin_coeff;
	logic [DATA_WIDTH-2:0] cos_uncert;
	logic [DATA_WIDTH-2:0] sin_uncert;

	modport source (output valid, cos_coeff, sin_coeff, cos_uncert, sin_uncert, input ready);
	modport sink (input valid, cos_coeff, sin_coeff, cos_uncert, sin_uncert, output ready);
endinterface

interface cap_out_if #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS = 16
);
	logic valid;
	logic ready;
	logic [DATA_WIDTH-1:0] amplitude;
	logic [FRAC_BITS+8:0] phase_deg;
	logic [DATA_WIDTH-1:0] amplitude_uncert;
	logic [DATA_WIDTH-1:0] phase_uncert_deg;

	modport source (output valid, amplitude, phase_deg, amplitude_uncert, phase_uncert_deg,
		input ready);
	modport sink (input valid, amplitude, phase_deg, amplitude_uncert, phase_uncert_deg,
		output ready);
endinterface

interface cap_cfg_if;
	logic valid;
	logic ready;
	logic [cap_pkg::FOLD_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/cap_delay.sv
`default_nettype none
module cap_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input logic clk,
	input logic en,
	input logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);
	generate
		if (DEPTH == 0) begin : g_none
			assign q = d;
		end else begin : g_line
			logic [WIDTH-1:0] line_q [DEPTH];
			always_ff @(posedge clk) begin
				if (en) begin
					line_q[0] <= d;
					for (int i = 1; i < DEPTH; i++) begin
						line_q[i] <= line_q[i-1];
					end
				end
			end
			assign q = line_q[DEPTH-1];
		end
	endgenerate
endmodule
`default_nettype wire

FILE: rtl/cap_sqrt_cell.sv
`default_nettype none
module cap_sqrt_cell #(
	parameter int N = 8,
	parameter int STEP = 0
) (
	input logic clk,
	input logic en,
	input logic [2*N-1:0] rem_i,
	input logic [2*N-1:0] res_i,
	output logic [2*N-1:0] rem_o,
	output logic [2*N-1:0] res_o
);
	localparam int SH = 2 * (N - 1 - STEP);
	localparam logic [2*N-1:0] BIT = (2*N)'(1) << SH;

	logic [2*N-1:0] trial;
	logic take;
	logic [2*N-1:0] rem_q;
	logic [2*N-1:0] res_q;

	assign trial = res_i + BIT;
	assign take = (rem_i >= trial);

	always_ff @(posedge clk) begin
		if (en) begin
			if (take) begin
				rem_q <= rem_i - trial;
				res_q <= (res_i >> 1) + BIT;
			end else begin
				rem_q <= rem_i;
				res_q <= res_i >> 1;
			end
		end
	end

	assign rem_o = rem_q;
	assign res_o = res_q;
endmodule
`default_nettype wire

FILE: rtl/cap_isqrt.sv
`default_nettype none
module cap_isqrt #(
	parameter int N = 8
) (
	input logic clk,
	input logic en,
	input logic [2*N-1:0] rad,
	output logic [N-1:0] root
);
	logic [2*N-1:0] rem_w [N+1];
	logic [2*N-1:0] res_w [N+1];

	assign rem_w[0] = rad;
	assign res_w[0] = '0;

	generate
		for (genvar k = 0; k < N; k++) begin : g_cell
			cap_sqrt_cell #(.N(N), .STEP(k)) u_cell (
				.clk(clk),
				.en(en),
				.rem_i(rem_w[k]),
				.res_i(res_w[k]),
				.rem_o(rem_w[k+1]),
				.res_o(res_w[k+1])
			);
		end
	endgenerate

	assign root = res_w[N][N-1:0];
endmodule
`default_nettype wire

FILE: rtl/cap_div_cell.sv
`default_nettype none
module cap_div_cell #(
	parameter int NW = 16,
	parameter int DW = 8,
	parameter int QW = 8,
	parameter int STEP = 0
) (
	input logic clk,
	input logic en,
	input logic [NW-1:0] rem_i,
	input logic [DW-1:0] den_i,
	input logic [QW-1:0] quo_i,
	output logic [NW-1:0] rem_o,
	output logic [DW-1:0] den_o,
	output logic [QW-1:0] quo_o
);
	localparam int CW = NW + DW;

	logic [CW-1:0] rem_x;
	logic [CW-1:0] sub_x;
	logic [CW-1:0] dif_x;
	logic take;
	logic [NW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [QW-1:0] quo_q;

	assign rem_x = CW'(rem_i);
	assign sub_x = CW'(den_i) << STEP;
	assign dif_x = rem_x - sub_x;
	assign take = (rem_x >= sub_x);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= take ? dif_x[NW-1:0] : rem_i;
			den_q <= den_i;
			quo_q <= {quo_i[QW-2:0], take};
		end
	end

	assign rem_o = rem_q;
	assign den_o = den_q;
	assign quo_o = quo_q;
endmodule
`default_nettype wire

FILE: rtl/cap_divide.sv
`default_nettype none
module cap_divide #(
	parameter int NW = 16,
	parameter int DW = 8,
	parameter int QW = 8
) (
	input logic clk,
	input logic en,
	input logic [NW-1:0] num,
	input logic [DW-1:0] den,
	output logic [QW-1:0] quo
);
	logic [NW-1:0] rem_w [QW+1];
	logic [DW-1:0] den_w [QW+1];
	logic [QW-1:0] quo_w [QW+1];

	assign rem_w[0] = num;
	assign den_w[0] = den;
	assign quo_w[0] = '0;

	generate
		for (genvar k = 0; k < QW; k++) begin : g_cell
			cap_div_cell #(.NW(NW), .DW(DW), .QW(QW), .STEP(QW - 1 - k)) u_cell (
				.clk(clk),
				.en(en),
				.rem_i(rem_w[k]),
				.den_i(den_w[k]),
				.quo_i(quo_w[k]),
				.rem_o(rem_w[k+1]),
				.den_o(den_w[k+1]),
				.quo_o(quo_w[k+1])
			);
		end
	endgenerate

	assign quo = quo_w[QW];
endmodule
`default_nettype wire

FILE: rtl/cap_cordic_cell.sv
`default_nettype none
module cap_cordic_cell #(
	parameter int STEP = 0
) (
	input logic clk,
	input logic en,
	input logic signed [cap_pkg::XW-1:0] x_i,
	input logic signed [cap_pkg::XW-1:0] y_i,
	input logic signed [cap_pkg::ZW-1:0] z_i,
	output logic signed [cap_pkg::XW-1:0] x_o,
	output logic signed [cap_pkg::XW-1:0] y_o,
	output logic signed [cap_pkg::ZW-1:0] z_o
);
	import cap_pkg::*;

	localparam logic signed [ZW-1:0] ANGLE = atan_deg(STEP);

	logic signed [XW-1:0] dx;
	logic signed [XW-1:0] dy;
	logic pos;
	logic signed [XW-1:0] x_q;
	logic signed [XW-1:0] y_q;
	logic signed [ZW-1:0] z_q;

	assign dx = y_i >>> STEP;
	assign dy = x_i >>> STEP;
	assign pos = !y_i[XW-1] && (y_i != '0);

	always_ff @(posedge clk) begin
		if (en) begin
			if (pos) begin
				x_q <= x_i + dx;
				y_q <= y_i - dy;
				z_q <= z_i + ANGLE;
			end else begin
				x_q <= x_i - dx;
				y_q <= y_i + dy;
				z_q <= z_i - ANGLE;
			end
		end
	end

	assign x_o = x_q;
	assign y_o = y_q;
	assign z_o = z_q;
endmodule
`default_nettype wire

FILE: rtl/cos_sin_to_amplitude_phase_unit.sv
// Channel  Role    Payload
// coeff    sink    cos_coeff, sin_coeff, cos_uncert, sin_uncert
// result   source  amplitude, phase_deg, amplitude_uncert, phase_uncert_deg
// cfg      sink    data (angular fold), always ready
//
// One item is taken per cycle unless a stalled result holds the full pipeline; the
// result latency is set by the amplitude uncertainty path (at W=32, F=16): two
// square-root cell rows and one divider row in series.
// Reset clears the valid bits and sets the fold to 2; there is no clearing pass.
// A stalled result holds the pipeline only once its last stage is also full.
`default_nettype none
module cos_sin_to_amplitude_phase_unit #(
	parameter int DATA_WIDTH = cap_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS = cap_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	cap_cfg_if.sink cfg,
	cap_in_if.sink coeff,
	cap_out_if.source result
);
	import cap_pkg::*;

	localparam int W = DATA_WIDTH;
	localparam int F = FRAC_BITS;
	localparam int PW = F + 9;
	localparam int NPW = 2 * W - 2 + F;
	localparam int OVW = NPW + W;
	localparam int VW = W + K_W + 2;
	localparam int LV_AMP = 3 + W;
	localparam int LV_AU = 3 * W + 4;
	localparam int LV_PU = 2 * W + 9;
	localparam int LV_PH = 32 + PW;
	localparam int LV_CORDIC = 31;
	localparam int LAT = max_int(max_int(LV_AU, LV_PU), LV_PH);
	localparam logic [PW-1:0] PH_LIMIT = PW'(360) << F;

	logic [FOLD_W-1:0] fold_q;
	logic [FOLD_W-1:0] fold_eff;
	logic [LAT-1:0] vld_q;
	logic out_vld_q;
	logic out_free;
	logic en;

	assign cfg.ready = 1'b1;
	assign fold_eff = (fold_q == '0) ? FOLD_W'(1) : fold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_q <= FOLD_RESET;
		end else if (cfg.valid) begin
			fold_q <= cfg.data;
		end
	end

	assign out_free = !out_vld_q || result.ready;
	assign en = out_free || !vld_q[LAT-1];
	assign coeff.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], coeff.valid};
		end
	end

	// Stage 1: input registers.
	logic [W-1:0] c_s1;
	logic [W-1:0] s_s1;
	logic [W-2:0] uc_s1;
	logic [W-2:0] us_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= coeff.cos_coeff;
			s_s1 <= coeff.sin_coeff;
			uc_s1 <= coeff.cos_uncert;
			us_s1 <= coeff.sin_uncert;
		end
	end

	// Stage 2: magnitudes, products and flags.
	logic [W-1:0] ac;
	logic [W-1:0] as_mag;
	logic [2*W-1:0] ac2_s2;
	logic [2*W-1:0] as2_s2;
	logic [2*W-3:0] acuc_s2;
	logic [2*W-3:0] asus_s2;
	logic [2*W-3:0] asuc_s2;
	logic [2*W-3:0] acus_s2;
	cap_flags_t flags_s2;

	assign ac = c_s1[W-1] ? (~c_s1 + W'(1)) : c_s1;
	assign as_mag = s_s1[W-1] ? (~s_s1 + W'(1)) : s_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ac2_s2 <= (2*W)'(ac) * (2*W)'(ac);
			as2_s2 <= (2*W)'(as_mag) * (2*W)'(as_mag);
			acuc_s2 <= (2*W-2)'(ac) * (2*W-2)'(uc_s1);
			asus_s2 <= (2*W-2)'(as_mag) * (2*W-2)'(us_s1);
			asuc_s2 <= (2*W-2)'(as_mag) * (2*W-2)'(uc_s1);
			acus_s2 <= (2*W-2)'(ac) * (2*W-2)'(us_s1);
			flags_s2.amp_zero <= (c_s1 == '0) && (s_s1 == '0);
			flags_s2.pu_zero <= (c_s1 == '0) || (s_s1 == '0);
		end
	end

	// Stage 3: sum of squares and scaled numerators.
	logic [2*W-1:0] d_s3;
	logic [NPW-1:0] np_s3;
	logic [NPW-1:0] nq_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s3 <= ac2_s2 + as2_s2;
			np_s3 <= {asuc_s2, {F{1'b0}}};
			nq_s3 <= {acus_s2, {F{1'b0}}};
		end
	end

	// Amplitude.
	logic [W-1:0] amp;

	cap_isqrt #(.N(W)) u_amp_sqrt (.clk(clk), .en(en), .rad(d_s3), .root(amp));

	// Amplitude uncertainty.
	logic [2*W-3:0] acuc_d;
	logic [2*W-3:0] asus_d;
	logic [W-2:0] ta;
	logic [W-2:0] tb;
	logic [2*W-3:0] ta2_q;
	logic [2*W-3:0] tb2_q;
	logic [2*W-2:0] ausum_q;
	logic [W-1:0] au;

	cap_delay #(.WIDTH(2*W-2), .DEPTH(W+1)) u_acuc_dly (
		.clk(clk), .en(en), .d(acuc_s2), .q(acuc_d));
	cap_delay #(.WIDTH(2*W-2), .DEPTH(W+1)) u_asus_dly (
		.clk(clk), .en(en), .d(asus_s2), .q(asus_d));

	cap_divide #(.NW(2*W-2), .DW(W), .QW(W-1)) u_ta_div (
		.clk(clk), .en(en), .num(acuc_d), .den(amp), .quo(ta));
	cap_divide #(.NW(2*W-2), .DW(W), .QW(W-1)) u_tb_div (
		.clk(clk), .en(en), .num(asus_d), .den(amp), .quo(tb));

	always_ff @(posedge clk) begin
		if (en) begin
			ta2_q <= (2*W-2)'(ta) * (2*W-2)'(ta);
			tb2_q <= (2*W-2)'(tb) * (2*W-2)'(tb);
			ausum_q <= (2*W-1)'(ta2_q) + (2*W-1)'(tb2_q);
		end
	end

	cap_isqrt #(.N(W)) u_au_sqrt (.clk(clk), .en(en), .rad((2*W)'(ausum_q)), .root(au));

	// Phase uncertainty.
	logic [2*W-1:0] d_s4;
	logic [NPW-1:0] np_s4;
	logic [NPW-1:0] nq_s4;
	logic [1:0] ovf_s4;
	logic [1:0] ovf_d;
	logic [W-1:0] p_quo;
	logic [W-1:0] q_quo;
	logic [W-1:0] p_sat;
	logic [W-1:0] q_sat;
	logic [2*W-1:0] pp_q;
	logic [2*W-1:0] qq_q;
	logic [2*W:0] pqsum_q;
	logic [W:0] r_root;
	logic [W+K_SPLIT:0] rl_q;
	logic [W+K_SPLIT:0] rh_q;
	logic [VW-1:0] v_sum;
	logic [W+7:0] v_sh;
	logic [W-1:0] pu_q;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s4 <= d_s3;
			np_s4 <= np_s3;
			nq_s4 <= nq_s3;
			ovf_s4[1] <= OVW'(np_s3) >= (OVW'(d_s3) << W);
			ovf_s4[0] <= OVW'(nq_s3) >= (OVW'(d_s3) << W);
		end
	end

	cap_divide #(.NW(NPW), .DW(2*W), .QW(W)) u_p_div (
		.clk(clk), .en(en), .num(np_s4), .den(d_s4), .quo(p_quo));
	cap_divide #(.NW(NPW), .DW(2*W), .QW(W)) u_q_div (
		.clk(clk), .en(en), .num(nq_s4), .den(d_s4), .quo(q_quo));
	cap_delay #(.WIDTH(2), .DEPTH(W)) u_ovf_dly (
		.clk(clk), .en(en), .d(ovf_s4), .q(ovf_d));

	assign p_sat = ovf_d[1] ? '1 : p_quo;
	assign q_sat = ovf_d[0] ? '1 : q_quo;

	always_ff @(posedge clk) begin
		if (en) begin
			pp_q <= (2*W)'(p_sat) * (2*W)'(p_sat);
			qq_q <= (2*W)'(q_sat) * (2*W)'(q_sat);
			pqsum_q <= (2*W+1)'(pp_q) + (2*W+1)'(qq_q);
		end
	end

	cap_isqrt #(.N(W+1)) u_r_sqrt (
		.clk(clk), .en(en), .rad((2*W+2)'(pqsum_q)), .root(r_root));

	assign v_sum = (VW'(rh_q) << K_SPLIT) + VW'(rl_q) + (VW'(1) << ROUND_BIT);
	assign v_sh = v_sum[OUT_SHIFT +: W+8];

	always_ff @(posedge clk) begin
		if (en) begin
			rl_q <= (W+K_SPLIT+1)'(r_root) * (W+K_SPLIT+1)'(K_LO);
			rh_q <= (W+K_SPLIT+1)'(r_root) * (W+K_SPLIT+1)'(K_HI);
			pu_q <= (v_sh[W+7:W] != '0) ? '1 : v_sh[W-1:0];
		end
	end

	// Phase: prepare, normalize, CORDIC, wrap, divide by fold.
	logic signed [XW-1:0] x0;
	logic signed [XW-1:0] y0;
	logic signed [XW-1:0] xp;
	logic signed [XW-1:0] yp;
	logic [XW-1:0] yabs;
	logic signed [XW-1:0] nx_q [NORM_STAGES+1];
	logic signed [XW-1:0] ny_q [NORM_STAGES+1];
	logic [XW-1:0] nm_q [NORM_STAGES+1];
	logic signed [ZW-1:0] nz_q [NORM_STAGES+1];

	assign x0 = {{(XW-W){s_s1[W-1]}}, s_s1};
	assign y0 = {{(XW-W){c_s1[W-1]}}, c_s1};
	assign xp = s_s1[W-1] ? -x0 : x0;
	assign yp = s_s1[W-1] ? -y0 : y0;
	assign yabs = yp[XW-1] ? XW'(-yp) : XW'(yp);

	always_ff @(posedge clk) begin
		if (en) begin
			nx_q[0] <= xp;
			ny_q[0] <= yp;
			nm_q[0] <= (yabs > XW'(xp)) ? yabs : XW'(xp);
			nz_q[0] <= s_s1[W-1] ? Q16_180 : '0;
		end
	end

	generate
		for (genvar i = 0; i < NORM_STAGES; i++) begin : g_norm
			localparam int SHIFT = 32 >> i;
			localparam logic [XW-1:0] LIMIT = XW'(1) << (NORM_TOP + 1 - SHIFT);
			always_ff @(posedge clk) begin
				if (en) begin
					if (nm_q[i] < LIMIT) begin
						nx_q[i+1] <= nx_q[i] <<< SHIFT;
						ny_q[i+1] <= ny_q[i] <<< SHIFT;
						nm_q[i+1] <= nm_q[i] << SHIFT;
					end else begin
						nx_q[i+1] <= nx_q[i];
						ny_q[i+1] <= ny_q[i];
						nm_q[i+1] <= nm_q[i];
					end
					nz_q[i+1] <= nz_q[i];
				end
			end
		end
	endgenerate

	logic signed [XW-1:0] cx_w [CORDIC_STEPS+1];
	logic signed [XW-1:0] cy_w [CORDIC_STEPS+1];
	logic signed [ZW-1:0] cz_w [CORDIC_STEPS+1];

	assign cx_w[0] = nx_q[NORM_STAGES];
	assign cy_w[0] = ny_q[NORM_STAGES];
	assign cz_w[0] = nz_q[NORM_STAGES];

	generate
		for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
			cap_cordic_cell #(.STEP(k)) u_cell (
				.clk(clk),
				.en(en),
				.x_i(cx_w[k]),
				.y_i(cy_w[k]),
				.z_i(cz_w[k]),
				.x_o(cx_w[k+1]),
				.y_o(cy_w[k+1]),
				.z_o(cz_w[k+1])
			);
		end
	endgenerate

	logic az_d;
	logic signed [ZW-1:0] zsel;
	logic signed [ZW-1:0] wa0;
	logic signed [ZW-1:0] wa1;
	logic [ANG_W-1:0] wa;
	logic [PW-1:0] ph_pre;
	logic [PW-1:0] ph_q;
	logic [PW-1:0] ph_quo;

	cap_delay #(.WIDTH(1), .DEPTH(LV_CORDIC - 2)) u_az_dly (
		.clk(clk), .en(en), .d(flags_s2.amp_zero), .q(az_d));

	assign zsel = az_d ? '0 : cz_w[CORDIC_STEPS];
	assign wa0 = Q16_90 - zsel;
	assign wa1 = (wa0 < 0) ? (wa0 + Q16_360) : ((wa0 >= Q16_360) ? (wa0 - Q16_360) : wa0);
	assign wa = wa1[ANG_W-1:0];

	generate
		if (F >= 16) begin : g_ph_left
			assign ph_pre = PW'(wa) << (F - 16);
		end else begin : g_ph_right
			localparam int RSH = 16 - F;
			logic [ANG_W:0] rnd;
			assign rnd = (ANG_W+1)'(wa) + ((ANG_W+1)'(1) << (RSH - 1));
			assign ph_pre = PW'(rnd >> RSH);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			ph_q <= ph_pre;
		end
	end

	cap_divide #(.NW(PW), .DW(FOLD_W), .QW(PW)) u_fold_div (
		.clk(clk), .en(en), .num(ph_q), .den(fold_eff), .quo(ph_quo));

	// Alignment to the common latency.
	logic [W-1:0] amp_d;
	logic [W-1:0] au_d;
	logic [W-1:0] pu_d;
	logic [PW-1:0] ph_d;
	cap_flags_t flags_d;

	cap_delay #(.WIDTH(W), .DEPTH(LAT - LV_AMP)) u_amp_dly (
		.clk(clk), .en(en), .d(amp), .q(amp_d));
	cap_delay #(.WIDTH(W), .DEPTH(LAT - LV_AU)) u_au_dly (
		.clk(clk), .en(en), .d(au), .q(au_d));
	cap_delay #(.WIDTH(W), .DEPTH(LAT - LV_PU)) u_pu_dly (
		.clk(clk), .en(en), .d(pu_q), .q(pu_d));
	cap_delay #(.WIDTH(PW), .DEPTH(LAT - LV_PH)) u_ph_dly (
		.clk(clk), .en(en), .d(ph_quo), .q(ph_d));
	cap_delay #(.WIDTH($bits(cap_flags_t)), .DEPTH(LAT - 2)) u_flags_dly (
		.clk(clk), .en(en), .d(flags_s2), .q(flags_d));

	// Output register.
	logic [W-1:0] amp_out_q;
	logic [W-1:0] au_out_q;
	logic [W-1:0] pu_out_q;
	logic [PW-1:0] ph_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= vld_q[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			amp_out_q <= amp_d;
			ph_out_q <= ph_d;
			au_out_q <= flags_d.amp_zero ? '0 : au_d;
			pu_out_q <= flags_d.pu_zero ? '0 : pu_d;
		end
	end

	assign result.valid = out_vld_q;
	assign result.amplitude = amp_out_q;
	assign result.phase_deg = ph_out_q;
	assign result.amplitude_uncert = au_out_q;
	assign result.phase_uncert_deg = pu_out_q;

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		coeff.valid && coeff.ready |=> vld_q[0])
		else $error("accepted transfer did not enter the pipeline");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready && vld_q[LAT-1] |-> !coeff.ready)
		else $error("input taken while the full pipeline is stalled");

	a_zero_amp_unc: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.amplitude == '0) |-> (result.amplitude_uncert == '0))
		else $error("amplitude uncertainty nonzero at zero amplitude");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.phase_deg <= PH_LIMIT))
		else $error("phase outside its range");

endmodule
`default_nettype wire
